[sv/ulidg_pkg.sv]
// Shared types, constants and the base32 character lookup for the ULID generator.
// Depends on nothing; every other file in this folder uses it by scoped names.
`default_nettype none

package ulidg_pkg;

  // Generator and format constants
  localparam logic [63:0] LCG_MUL         = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD         = 64'd1442695040888963407;
  localparam logic [63:0] ZERO_SEED_SUBST = 64'h9e3779b97f4a7c15;
  localparam int unsigned TOP_BYTE_SHIFT  = 56;
  localparam int unsigned ULID_CHARS      = 26;
  localparam int unsigned TIME_BITS       = 50;
  localparam int unsigned RAND_STEPS      = 10;
  localparam int unsigned RAND_BITS       = 80;
  localparam int unsigned WORD_BITS       = TIME_BITS + RAND_BITS;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [32*8-1:0] ALPHA_STR = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

  // Input item
  typedef struct packed {
    logic signed [63:0] stamp_ms;
    logic [63:0]        seed_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
    logic       fail;
  } out_item_t;

  // One classified and expanded item, queued between front and back
  typedef struct packed {
    logic                 fail;
    logic [TIME_BITS-1:0] time_lo;
    logic [RAND_BITS-1:0] rnd;
  } entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Front sequencer states
  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_ADD  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  // Map a 5-bit value to its Crockford base32 ASCII code
  function automatic logic [6:0] b32_char(input logic [4:0] v);
    logic [4:0] r;
    r = 5'd31 - v;
    return ALPHA_STR[{r, 3'b000} +: 7];
  endfunction

endpackage

`default_nettype wire

[sv/ulidg_front.sv]
// Front part: accepts items, classifies negative timestamps and runs ten LCG steps on the rest.
// Depends on ulidg_pkg; pushes one entry per item into the queue.
`default_nettype none

module ulidg_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ulidg_pkg::in_item_t in_item_i,
  input  wire ulidg_pkg::q_stat_t  q_stat_i,
  output logic                   push_o,
  output ulidg_pkg::entry_t      entry_o
);

  ulidg_pkg::front_state_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [63:0] x_q, x_d;
  logic [63:0] p_q, p_d;
  logic [31:0] cross_q, cross_d;
  logic        fail_q, fail_d;
  logic [ulidg_pkg::TIME_BITS-1:0] time_q, time_d;
  logic [ulidg_pkg::RAND_BITS-1:0] rnd_q, rnd_d;
  logic        accept;
  logic [63:0] x_next;

  assign in_stall_o = (state_q != ulidg_pkg::F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (state_q == ulidg_pkg::F_PUSH) && !q_stat_i.full;
  assign entry_o    = '{fail: fail_q, time_lo: time_q, rnd: rnd_q};

  // Finish one LCG step from the registered partial products
  assign x_next = p_q + {cross_q, 32'b0} + ulidg_pkg::LCG_ADD;

  // Sequence accept, multiply/add steps and push
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    x_d     = x_q;
    p_d     = p_q;
    cross_d = cross_q;
    fail_d  = fail_q;
    time_d  = time_q;
    rnd_d   = rnd_q;
    case (state_q)
      ulidg_pkg::F_IDLE: begin
        if (accept) begin
          fail_d  = in_item_i.stamp_ms[63];
          time_d  = in_item_i.stamp_ms[ulidg_pkg::TIME_BITS-1:0];
          x_d     = (in_item_i.seed_value == 64'd0) ? ulidg_pkg::ZERO_SEED_SUBST
                                                    : in_item_i.seed_value;
          step_d  = 4'd0;
          state_d = in_item_i.stamp_ms[63] ? ulidg_pkg::F_PUSH : ulidg_pkg::F_MUL;
        end
      end
      ulidg_pkg::F_MUL: begin
        // Low product and the two truncated cross products
        p_d     = {32'b0, x_q[31:0]} * {32'b0, ulidg_pkg::LCG_MUL[31:0]};
        cross_d = (x_q[63:32] * ulidg_pkg::LCG_MUL[31:0])
                + (x_q[31:0] * ulidg_pkg::LCG_MUL[63:32]);
        state_d = ulidg_pkg::F_ADD;
      end
      ulidg_pkg::F_ADD: begin
        x_d    = x_next;
        rnd_d  = {rnd_q[ulidg_pkg::RAND_BITS-9:0], x_next[63:ulidg_pkg::TOP_BYTE_SHIFT]};
        step_d = step_q + 4'd1;
        state_d = (step_q == 4'(ulidg_pkg::RAND_STEPS - 1)) ? ulidg_pkg::F_PUSH
                                                             : ulidg_pkg::F_MUL;
      end
      ulidg_pkg::F_PUSH: begin
        if (!q_stat_i.full) begin
          state_d = ulidg_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = ulidg_pkg::F_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ulidg_pkg::F_IDLE;
      step_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    p_q     <= p_d;
    cross_q <= cross_d;
    fail_q  <= fail_d;
    time_q  <= time_d;
    rnd_q   <= rnd_d;
  end

endmodule

`default_nettype wire

[sv/ulidg_queue.sv]
// Small register queue of expanded entries between front and back.
// Depends on ulidg_pkg for the entry and status types.
`default_nettype none

module ulidg_queue #(
  parameter int unsigned Depth = ulidg_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ulidg_pkg::entry_t entry_i,
  input  wire logic              pop_i,
  output ulidg_pkg::entry_t      head_o,
  output ulidg_pkg::q_stat_t     stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ulidg_pkg::entry_t slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign head_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[sv/ulidg_back.sv]
// Back part: turns each queued entry into 26 base32 characters, or one error result.
// Depends on ulidg_pkg; drives the registered output channel.
`default_nettype none

module ulidg_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ulidg_pkg::entry_t  head_i,
  input  wire ulidg_pkg::q_stat_t q_stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ulidg_pkg::out_item_t    out_item_o
);

  logic [4:0] cnt_q;
  logic       out_valid_q;
  ulidg_pkg::out_item_t out_q;
  logic       load;
  logic       last;
  logic [7:0] base;
  logic [ulidg_pkg::WORD_BITS-1:0] word;
  logic [4:0] digit;

  // Pick the current 5-bit digit, most significant first
  assign word  = {head_i.time_lo, head_i.rnd};
  assign base  = 8'(ulidg_pkg::WORD_BITS - 5) - ({3'b0, cnt_q} * 8'd5);
  assign digit = word[base +: 5];
  assign last  = (cnt_q == 5'(ulidg_pkg::ULID_CHARS - 1));

  assign load  = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o = load && (head_i.fail || last);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Advance the character count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cnt_q       <= pop_o ? 5'd0 : cnt_q + 5'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the next result item
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.fail) begin
        out_q <= '{char_code: 7'd0, last_char: 1'b1, fail: 1'b1};
      end else begin
        out_q <= '{char_code: ulidg_pkg::b32_char(digit), last_char: last, fail: 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[sv/seeded_ulid_generator.sv]
// Top level of the seeded ULID generator: front, queue and back joined.
// Depends on ulidg_pkg, ulidg_front, ulidg_queue and ulidg_back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | ulidg_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | ulidg_pkg::out_item_t
//
// A valid item passes the front in order: accept, ten LCG steps (each a state
// forming partial products through 32x32 multipliers, then a 64-bit add state)
// and push, which waits while the queue is full; a negative timestamp goes
// straight from accept to push. The back emits one character per cycle, 26 per
// item, from the queue head while it is not empty and out_stall_i stays low.
// Reset clears all control state; there is nothing else to clear.
// Output stalls back up through the queue into in_stall_o.
`default_nettype none

module seeded_ulid_generator #(
  parameter int unsigned QueueDepth = ulidg_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ulidg_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ulidg_pkg::out_item_t      out_item_o
);

  logic               push;
  logic               pop;
  ulidg_pkg::entry_t  entry;
  ulidg_pkg::entry_t  head;
  ulidg_pkg::q_stat_t q_stat;

  ulidg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (entry)
  );

  ulidg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  ulidg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("push into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // An error result carries code zero and closes the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.fail) |-> (out_item_o.last_char && out_item_o.char_code == 7'd0))
    else $error("malformed error result");

endmodule

`default_nettype wire
